// ----- rtl/bpgd_pkg.sv -----
// Shared types, event codes, register indexes and reset values for the
// button press gesture detector. No dependencies.
package bpgd_pkg;

   // Integrator, stamp, count, event code and register index widths
   localparam int LevelWidth = 8;
   localparam int TickWidth  = 32;
   localparam int CountWidth = 8;
   localparam int EventWidth = 3;
   localparam int CsrIdxWidth = 2;

   // Default integrator depth
   localparam int DebounceDepthDefault = 16;

   // Gesture event codes
   localparam logic [EventWidth-1:0] EvNone    = 3'd0;
   localparam logic [EventWidth-1:0] EvShort   = 3'd1;
   localparam logic [EventWidth-1:0] EvMcu     = 3'd2;
   localparam logic [EventWidth-1:0] EvFull    = 3'd3;
   localparam logic [EventWidth-1:0] EvFactory = 3'd4;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] RegClickWindow = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegMcuHold     = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegFullHold    = 2'd2;
   localparam logic [CsrIdxWidth-1:0] RegFactory     = 2'd3;

   // Register reset values
   localparam logic [TickWidth-1:0]  ClickWindowReset = 32'd16000000;
   localparam logic [TickWidth-1:0]  McuHoldReset     = 32'd80000000;
   localparam logic [TickWidth-1:0]  FullHoldReset    = 32'd160000000;
   localparam logic [CountWidth-1:0] FactoryReset     = 8'd5;

   typedef struct packed {
      logic                 pin_level;
      logic [TickWidth-1:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic [EventWidth-1:0] gesture_event;
      logic                  busy_res;
      logic [CountWidth-1:0] click_total;
   } rsp_type;

   typedef struct packed {
      logic [TickWidth-1:0]  click_window;
      logic [TickWidth-1:0]  mcu_hold;
      logic [TickWidth-1:0]  full_hold;
      logic [CountWidth-1:0] factory_clicks;
   } cfg_type;

endpackage

// ----- rtl/bpgd_core.sv -----
// Gesture state registers and the per-poll update logic.
// Depends on bpgd_pkg.
module bpgd_core #(
   parameter int DEBOUNCE_DEPTH = bpgd_pkg::DebounceDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  bpgd_pkg::req_type poll,
   input  bpgd_pkg::cfg_type cfg,
   output bpgd_pkg::rsp_type result
);

   localparam logic [bpgd_pkg::LevelWidth-1:0] DepthLvl =
      bpgd_pkg::LevelWidth'(DEBOUNCE_DEPTH);
   localparam logic [bpgd_pkg::LevelWidth-1:0] LvlOne = bpgd_pkg::LevelWidth'(1);

   logic [bpgd_pkg::LevelWidth-1:0] level_ff, level_in;
   logic                            pressed_ff, pressed_in;
   logic                            released_ff, released_in;
   logic [bpgd_pkg::TickWidth-1:0]  press_stamp_ff, press_stamp_in;
   logic [bpgd_pkg::TickWidth-1:0]  release_stamp_ff, release_stamp_in;
   logic [bpgd_pkg::CountWidth-1:0] count_ff, count_in;

   logic [bpgd_pkg::TickWidth-1:0]  since_release;
   logic [bpgd_pkg::TickWidth-1:0]  since_press;
   logic [bpgd_pkg::TickWidth-1:0]  since_release_upd;
   logic [bpgd_pkg::EventWidth-1:0] event_code;

   // Integrate the pin, qualify edges, classify gestures
   always_comb begin
      level_in         = level_ff;
      pressed_in       = pressed_ff;
      released_in      = released_ff;
      press_stamp_in   = press_stamp_ff;
      release_stamp_in = release_stamp_ff;
      count_in         = count_ff;
      event_code       = bpgd_pkg::EvNone;

      since_release = poll.now_ticks - release_stamp_ff;

      if (!poll.pin_level) begin
         if (level_ff < DepthLvl) begin
            level_in = level_ff + 1'b1;
            if (level_in == DepthLvl) begin
               pressed_in     = 1'b1;
               press_stamp_in = poll.now_ticks;
               if (!(since_release > cfg.click_window)) begin
                  if (count_ff != '1) count_in = count_ff + 1'b1;
               end else begin
                  count_in = bpgd_pkg::CountWidth'(1);
               end
            end
         end
      end else begin
         if (level_ff > LvlOne) begin
            level_in = level_ff - 1'b1;
            if (level_in == LvlOne && pressed_ff) begin
               released_in      = 1'b1;
               release_stamp_in = poll.now_ticks;
            end
         end
      end

      since_press       = poll.now_ticks - press_stamp_in;
      since_release_upd = poll.now_ticks - release_stamp_in;

      priority if (pressed_in && released_in) begin
         pressed_in  = 1'b0;
         released_in = 1'b0;
         priority if (since_press > cfg.full_hold) event_code = bpgd_pkg::EvFull;
         else if (since_press > cfg.mcu_hold)      event_code = bpgd_pkg::EvMcu;
         else                                      event_code = bpgd_pkg::EvShort;
      end else if (!pressed_in) begin
         if (since_release_upd > cfg.click_window) begin
            if (count_in != '0 && count_in == cfg.factory_clicks)
               event_code = bpgd_pkg::EvFactory;
            count_in = '0;
         end
      end else begin
         event_code = bpgd_pkg::EvNone;
      end

      result.gesture_event = event_code;
      result.busy_res      = (level_in != LvlOne && level_in != DepthLvl)
                             || pressed_in || (count_in != '0);
      result.click_total   = count_in;
   end

   // Commit state on each processed poll
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff         <= LvlOne;
         pressed_ff       <= 1'b0;
         released_ff      <= 1'b0;
         press_stamp_ff   <= '0;
         release_stamp_ff <= '0;
         count_ff         <= '0;
      end else if (step_en) begin
         level_ff         <= level_in;
         pressed_ff       <= pressed_in;
         released_ff      <= released_in;
         press_stamp_ff   <= press_stamp_in;
         release_stamp_ff <= release_stamp_in;
         count_ff         <= count_in;
      end
   end

endmodule

// ----- rtl/button_press_gesture_detector_unit.sv -----
// Top level of the button press gesture detector: poll register, result
// register and control registers. Depends on bpgd_pkg and bpgd_core.
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      bpgd_pkg::req_type
//   rsp_     out        valid / stall      bpgd_pkg::rsp_type
//   csr_     in         valid / ready      index (2 bits), data (32 bits)
//
// One poll per cycle sustained while the result is not stalled. Each poll
// moves from the poll register into the result register, fed by one pass of
// the update logic. Reset is synchronous; the unit accepts polls right after.
// A stalled result holds and backs up into the poll register; req_stall
// rises only when both registers are full and the result cannot move.
module button_press_gesture_detector_unit #(
   parameter int DEBOUNCE_DEPTH = bpgd_pkg::DebounceDepthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bpgd_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bpgd_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpgd_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [bpgd_pkg::TickWidth-1:0]      csr_data
);

   logic              poll_valid_ff;
   bpgd_pkg::req_type poll_ff;
   logic              rsp_valid_ff;
   bpgd_pkg::rsp_type rsp_ff;
   bpgd_pkg::cfg_type cfg_ff;
   bpgd_pkg::rsp_type step_result;
   logic              advance;
   logic              poll_load;

   // Move the held poll into the result register when it has room
   assign advance   = poll_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = poll_valid_ff && !advance;
   assign poll_load = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   bpgd_core #(
      .DEBOUNCE_DEPTH(DEBOUNCE_DEPTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .poll    (poll_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   // Poll register
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else if (poll_load) begin
         poll_valid_ff <= 1'b1;
      end else if (advance) begin
         poll_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (poll_load) poll_ff <= req_payload;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= step_result;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Control registers: take each write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_window   <= bpgd_pkg::ClickWindowReset;
         cfg_ff.mcu_hold       <= bpgd_pkg::McuHoldReset;
         cfg_ff.full_hold      <= bpgd_pkg::FullHoldReset;
         cfg_ff.factory_clicks <= bpgd_pkg::FactoryReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpgd_pkg::RegClickWindow: cfg_ff.click_window <= csr_data;
            bpgd_pkg::RegMcuHold:     cfg_ff.mcu_hold     <= csr_data;
            bpgd_pkg::RegFullHold:    cfg_ff.full_hold    <= csr_data;
            bpgd_pkg::RegFactory:     cfg_ff.factory_clicks <=
               csr_data[bpgd_pkg::CountWidth-1:0];
            default: ;
         endcase
      end
   end

endmodule
